>>> sv/fpsl_pkg.sv
package fpsl_pkg;

  // Fixed field widths.
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned PULSE_W = 11;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned PID_W   = 32;

  // Shared multiplier operands: coefficient side and data side.
  localparam int unsigned MUL_A_W = 26;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Accumulator for both the filter sum and the three-term sum.
  localparam int unsigned ACC_W = 45;

  // Reciprocal division of the filter magnitude: dividend is below 2^RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned N_W         = RECIP_SHIFT;
  localparam int unsigned Q_W         = 16;

  // Tap weights fit this width for every supported tap count.
  localparam int unsigned WGT_W = 9;

  // Limits of speed and pulse.
  localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 16'sd25600;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -16'sd25600;
  localparam logic [PULSE_W-1:0]        PULSE_BASE = 11'd1100;
  localparam logic signed [ACC_W-1:0]   PID_ROUND  = 45'sd32768;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TARGET = 2'd0,
    REG_GAIN_P = 2'd1,
    REG_GAIN_I = 2'd2,
    REG_GAIN_D = 2'd3
  } reg_idx_e;

  // Saturate a speed value to plus or minus 100 percent.
  function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > SPEED_MAX) begin
      r = SPEED_MAX;
    end else if (v < SPEED_MIN) begin
      r = SPEED_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> sv/fpsl_hist_mem.sv
module fpsl_hist_mem #(
  parameter int unsigned DEPTH = 17,
  parameter int unsigned AW    = 5
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [fpsl_pkg::SPEED_W-1:0]   wdata_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [fpsl_pkg::SPEED_W-1:0]   rdata_o
);
  import fpsl_pkg::*;

  logic [SPEED_W-1:0] mem_q [DEPTH];
  logic [SPEED_W-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fpsl_mul.sv
module fpsl_mul (
  input  logic                                 clk_i,
  input  logic signed [fpsl_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [fpsl_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [fpsl_pkg::MUL_P_W-1:0]  p_o
);
  import fpsl_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // Signed product, registered before any use.
  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> sv/filtered_pid_speed_loop_unit.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  speed_sample
// m_axis    out  m_axis_tvalid/m_axis_tready  drive_level, pulse_width_us, filtered_speed
// cfg       in   cfg_we_i                     setpoint, gain_p, gain_i, gain_d
//
// One sample runs from its transfer to the result register through the single shared
// multiplier: one tap per cycle, newest first, then read and product latency, then two
// products for the reciprocal division and three for the controller terms. The input is
// ready again in the cycle after the result register is loaded.
// Reset clears the history through a fill count, so no clearing pass is needed.
// The input is not ready while a sample is in work; a waiting result holds back only
// the final load of the next one.
module filtered_pid_speed_loop_unit #(
  parameter int unsigned FILTER_TAPS = 17
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // speed_sample [15:0]
  input  logic [15:0]                           s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // drive_level [15:0], pulse_width_us [26:16], filtered_speed [42:27], zero [47:43]
  output logic [47:0]                           m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [fpsl_pkg::GAIN_W-1:0]           cfg_wdata_i
);
  import fpsl_pkg::*;

  localparam int unsigned AW       = $clog2(FILTER_TAPS);
  localparam int unsigned CW       = $clog2(FILTER_TAPS + 1);
  localparam int unsigned FIR_DIV  = 16 * FILTER_TAPS + (5 * FILTER_TAPS * (FILTER_TAPS - 1)) / 2;
  localparam int unsigned HALF_DIV = FIR_DIV / 2;
  localparam int unsigned RECIP    = (1 << RECIP_SHIFT) / FIR_DIV;
  localparam int unsigned W_MAX    = 16 + 5 * (FILTER_TAPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIR, ST_ABS, ST_RECIP, ST_QEST, ST_QD, ST_CORR,
    ST_ERR, ST_P0, ST_P1, ST_P2, ST_P3, ST_RND, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [SPEED_W-1:0] target_q;
  logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;

  // Long-lived loop state.
  logic [AW-1:0]             slot_q;
  logic [CW-1:0]             fill_q;
  logic signed [ERR_W-1:0]   e1_q, e2_q, err_q;
  logic signed [PID_W-1:0]   pid_acc_q;

  // Per-sample working registers.
  logic signed [MUL_A_W-1:0] a0_q, a1_q, a2_q;
  logic [AW-1:0]             rd_addr_q;
  logic [CW-1:0]             iss_cnt_q;
  logic [WGT_W-1:0]          wgt_q, wgt_p1_q;
  logic                      v1_q, v2_q, tap_ok_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [N_W-1:0]            n_q;
  logic                      neg_q;
  logic [Q_W-1:0]            q_q;
  logic signed [SPEED_W-1:0] filt_q;

  // Result register.
  logic                      out_vld_q;
  logic [47:0]               out_data_q;

  logic                      in_xfer;
  logic signed [SPEED_W-1:0] sample_c;
  logic [SPEED_W-1:0]        rd_data;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   acc_neg;
  logic [N_W-1:0]            mag;
  logic [MUL_B_W-1:0]        rem;
  logic [Q_W-1:0]            q_fin;
  logic signed [SPEED_W-1:0] tgt_c;
  logic signed [ACC_W-1:0]   sum_r;
  logic signed [PID_W:0]     pid_sum;
  logic signed [PID_W-1:0]   pid_next;
  logic signed [SPEED_W-1:0] drive;
  logic [SPEED_W:0]          drive_off;
  logic [PULSE_W-1:0]        pulse;
  logic                      out_free;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign sample_c      = clamp_speed(signed'(s_axis_tdata));
  assign tgt_c         = clamp_speed(target_q);

  fpsl_hist_mem #(
    .DEPTH (FILTER_TAPS),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (slot_q),
    .wdata_i (sample_c),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_FIR: begin
        mul_a = MUL_A_W'(wgt_p1_q);
        mul_b = tap_ok_q ? {{(MUL_B_W-SPEED_W){rd_data[SPEED_W-1]}}, rd_data} : '0;
      end
      ST_RECIP: begin
        mul_a = MUL_A_W'(RECIP);
        mul_b = {1'b0, n_q};
      end
      ST_QD: begin
        mul_a = MUL_A_W'(FIR_DIV);
        mul_b = {{(MUL_B_W-Q_W){1'b0}}, q_q};
      end
      ST_P0: begin
        mul_a = a0_q;
        mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      ST_P1: begin
        mul_a = a1_q;
        mul_b = {{(MUL_B_W-ERR_W){e1_q[ERR_W-1]}}, e1_q};
      end
      ST_P2: begin
        mul_a = a2_q;
        mul_b = {{(MUL_B_W-ERR_W){e2_q[ERR_W-1]}}, e2_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fpsl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Division of the filter sum: magnitude and quotient correction; the sign is applied in the sequencer.
  always_comb begin
    acc_neg = -acc_q;
    mag     = acc_q[ACC_W-1] ? acc_neg[N_W-1:0] : acc_q[N_W-1:0];
    rem     = {1'b0, n_q} - prod[MUL_B_W-1:0];
    q_fin   = (rem >= MUL_B_W'(FIR_DIV)) ? q_q + 1'b1 : q_q;
  end

  // Rounding of the three-term sum and saturating accumulation.
  always_comb begin
    sum_r   = acc_q + PID_ROUND;
    pid_sum = (PID_W+1)'(pid_acc_q) + (PID_W+1)'(signed'(sum_r[ACC_W-1:16]));
    if (pid_sum[PID_W] != pid_sum[PID_W-1]) begin
      pid_next = pid_sum[PID_W] ? {1'b1, {(PID_W-1){1'b0}}} : {1'b0, {(PID_W-1){1'b1}}};
    end else begin
      pid_next = pid_sum[PID_W-1:0];
    end
  end

  // Drive clamp and servo pulse mapping.
  always_comb begin
    if (pid_acc_q > PID_W'(SPEED_MAX)) begin
      drive = SPEED_MAX;
    end else if (pid_acc_q < PID_W'(SPEED_MIN)) begin
      drive = SPEED_MIN;
    end else begin
      drive = pid_acc_q[SPEED_W-1:0];
    end
    drive_off = (SPEED_W+1)'(drive) + (SPEED_W+1)'(SPEED_MAX);
    pulse     = PULSE_BASE + PULSE_W'(drive_off[SPEED_W-1:6]);
  end

  // Sequencer, loop state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      target_q   <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      slot_q     <= '0;
      fill_q     <= '0;
      e1_q       <= '0;
      e2_q       <= '0;
      err_q      <= '0;
      pid_acc_q  <= '0;
      a0_q       <= '0;
      a1_q       <= '0;
      a2_q       <= '0;
      rd_addr_q  <= '0;
      iss_cnt_q  <= '0;
      wgt_q      <= '0;
      wgt_p1_q   <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      tap_ok_q   <= 1'b0;
      acc_q      <= '0;
      n_q        <= '0;
      neg_q      <= 1'b0;
      q_q        <= '0;
      filt_q     <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET: target_q <= cfg_wdata_i[SPEED_W-1:0];
          REG_GAIN_P: gain_p_q <= cfg_wdata_i;
          REG_GAIN_I: gain_i_q <= cfg_wdata_i;
          REG_GAIN_D: gain_d_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // The output step reloads the result register itself.
      if (out_vld_q && m_axis_tready && state_q != ST_OUT) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            rd_addr_q <= slot_q;
            slot_q    <= (slot_q == AW'(FILTER_TAPS - 1)) ? '0 : slot_q + 1'b1;
            fill_q    <= (fill_q == CW'(FILTER_TAPS)) ? fill_q : fill_q + 1'b1;
            iss_cnt_q <= '0;
            wgt_q     <= WGT_W'(W_MAX);
            v1_q      <= 1'b0;
            v2_q      <= 1'b0;
            acc_q     <= '0;
            a0_q      <= MUL_A_W'(gain_p_q) + MUL_A_W'(gain_i_q) + MUL_A_W'(gain_d_q);
            a1_q      <= -MUL_A_W'(gain_p_q) - (MUL_A_W'(gain_d_q) <<< 1);
            a2_q      <= MUL_A_W'(gain_d_q);
            state_q   <= ST_FIR;
          end
        end
        ST_FIR: begin
          // Issue one tap a cycle, newest first; read, product and sum follow.
          v1_q     <= (iss_cnt_q != CW'(FILTER_TAPS));
          tap_ok_q <= CW'(rd_addr_q) < fill_q;
          wgt_p1_q <= wgt_q;
          v2_q     <= v1_q;
          if (v2_q) begin
            acc_q <= acc_q + prod[ACC_W-1:0];
          end
          if (iss_cnt_q != CW'(FILTER_TAPS)) begin
            iss_cnt_q <= iss_cnt_q + 1'b1;
            wgt_q     <= wgt_q - WGT_W'(5);
            rd_addr_q <= (rd_addr_q == '0) ? AW'(FILTER_TAPS - 1) : rd_addr_q - 1'b1;
          end else if (!v1_q && !v2_q) begin
            state_q <= ST_ABS;
          end
        end
        ST_ABS: begin
          n_q     <= mag + N_W'(HALF_DIV);
          neg_q   <= acc_q[ACC_W-1];
          state_q <= ST_RECIP;
        end
        ST_RECIP: begin
          state_q <= ST_QEST;
        end
        ST_QEST: begin
          q_q     <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
          state_q <= ST_QD;
        end
        ST_QD: begin
          state_q <= ST_CORR;
        end
        ST_CORR: begin
          filt_q  <= neg_q ? -signed'(q_fin) : signed'(q_fin);
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q   <= ERR_W'(tgt_c) - ERR_W'(filt_q);
          state_q <= ST_P0;
        end
        ST_P0: begin
          state_q <= ST_P1;
        end
        ST_P1: begin
          acc_q   <= prod[ACC_W-1:0];
          state_q <= ST_P2;
        end
        ST_P2: begin
          acc_q   <= acc_q + prod[ACC_W-1:0];
          state_q <= ST_P3;
        end
        ST_P3: begin
          acc_q   <= acc_q + prod[ACC_W-1:0];
          state_q <= ST_RND;
        end
        ST_RND: begin
          pid_acc_q <= pid_next;
          e2_q      <= e1_q;
          e1_q      <= err_q;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= {5'b0, filt_q, pulse, drive};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A result appears only from the final sequencer step.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output step");

  // The pulse stays inside the servo range.
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[26:16] >= 11'd1100 && m_axis_tdata[26:16] <= 11'd1900))
    else $error("pulse width out of range");

  // The history fill count never passes the tap count.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(FILTER_TAPS))
    else $error("history fill count overflow");

  // The filter pipeline is drained before the division starts.
  a_fir_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ABS) |-> (!v1_q && !v2_q && iss_cnt_q == CW'(FILTER_TAPS)))
    else $error("filter sum taken before all taps were added");

endmodule
